@@ rtl/assert_macros.svh @@
// assertion macros shared by the vector unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off during reset
`define V3A_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("%m: assertion failed");

// antecedent in one cycle implies consequent in the next
`define V3A_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ rtl/v3a_pkg.sv @@
// types, constants and helper functions of the vector unit
package v3a_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int FIELD_BITS = 32;
   localparam int CMD_BITS   = 3;
   localparam int IO_BITS    = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam int PROD_BITS  = 2 * IO_BITS;
   localparam int WIDE_BITS  = 2 * IO_BITS + 2;
   localparam int ROOT_BITS  = IO_BITS;
   localparam int REM_BITS   = IO_BITS + 2;
   localparam int QUOT_BITS  = FRAC_BITS + 1;

   typedef logic [CMD_BITS-1:0]         cmd_type;
   typedef logic signed [IO_BITS-1:0]   word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;
   typedef logic [PROD_BITS-1:0]        rad_type;
   typedef logic [ROOT_BITS-1:0]        root_type;
   typedef logic [REM_BITS-1:0]         rem_type;
   typedef logic [IO_BITS-1:0]          mag_type;
   typedef logic [QUOT_BITS-1:0]        quot_type;
   typedef logic [2:0][QUOT_BITS-1:0]   quot_vec_type;

   localparam cmd_type CMD_ADD   = 3'd0;
   localparam cmd_type CMD_CROSS = 3'd1;
   localparam cmd_type CMD_DOT   = 3'd2;
   localparam cmd_type CMD_MAG   = 3'd3;
   localparam cmd_type CMD_SCALE = 3'd4;
   localparam cmd_type CMD_NEG   = 3'd5;
   localparam cmd_type CMD_NORM  = 3'd6;
   localparam cmd_type CMD_SPARE = 3'd7;

   localparam logic [IO_BITS-1:0] WORD_MAX = {1'b0, {(IO_BITS-1){1'b1}}};
   localparam logic [IO_BITS-1:0] WORD_MIN = {1'b1, {(IO_BITS-1){1'b0}}};
   localparam wide_type WIDE_MAX =
      {{(WIDE_BITS-IO_BITS+1){1'b0}}, {(IO_BITS-1){1'b1}}};
   localparam wide_type WIDE_MIN = ~WIDE_MAX;
   localparam quot_type ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      cmd_type                 cmd;
      logic [2:0][IO_BITS-1:0] a;
      logic [2:0][IO_BITS-1:0] b;
      logic [IO_BITS-1:0]      sc;
   } req_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [2:0][IO_BITS-1:0] r;
      logic                    ovf;
      logic [2:0][IO_BITS-1:0] mag;
      logic [2:0]              neg;
   } side_type;

   typedef struct packed {
      logic               ovf;
      logic [IO_BITS-1:0] val;
   } sat_type;

   function automatic sat_type sat_word(input wide_type v);
      sat_type s;
      if (v > WIDE_MAX) begin
         s.ovf = 1'b1;
         s.val = WORD_MAX;
      end else if (v < WIDE_MIN) begin
         s.ovf = 1'b1;
         s.val = WORD_MIN;
      end else begin
         s.ovf = 1'b0;
         s.val = v[IO_BITS-1:0];
      end
      return s;
   endfunction

endpackage

@@ rtl/v3a_req_if.sv @@
// request channel of the vector unit
interface v3a_req_if;
   import v3a_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [CMD_BITS-1:0]          cmd;
   logic signed [FIELD_BITS-1:0] ax;
   logic signed [FIELD_BITS-1:0] ay;
   logic signed [FIELD_BITS-1:0] az;
   logic signed [FIELD_BITS-1:0] bx;
   logic signed [FIELD_BITS-1:0] by;
   logic signed [FIELD_BITS-1:0] bz;
   logic signed [FIELD_BITS-1:0] scale;

   modport source (output valid, cmd, ax, ay, az, bx, by, bz, scale, input ready);
   modport sink (input valid, cmd, ax, ay, az, bx, by, bz, scale, output ready);
endinterface

@@ rtl/v3a_rsp_if.sv @@
// response channel of the vector unit
interface v3a_rsp_if;
   import v3a_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] res_x;
   logic signed [FIELD_BITS-1:0] res_y;
   logic signed [FIELD_BITS-1:0] res_z;
   logic                         overflow;
   logic                         divide_by_zero;

   modport source (output valid, res_x, res_y, res_z, overflow, divide_by_zero,
                   input ready);
   modport sink (input valid, res_x, res_y, res_z, overflow, divide_by_zero,
                 output ready);
endinterface

@@ rtl/v3a_front.sv @@
// operand capture, multipliers, sums and saturation (four stages)
module v3a_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  v3a_pkg::req_type  in_req,
   output logic              out_valid,
   output v3a_pkg::side_type out_side,
   output v3a_pkg::rad_type  out_rad
);
   import v3a_pkg::*;

   logic     v1_ff;
   cmd_type  cmd1_ff;
   word_type a1_ff [3];
   word_type b1_ff [3];
   word_type sc1_ff;

   word_type mx [3];
   word_type my [3];
   word_type qx [3];
   word_type qy [3];
   prod_type p2_in [3];
   prod_type q2_in [3];

   logic     v2_ff;
   cmd_type  cmd2_ff;
   word_type a2_ff [3];
   word_type b2_ff [3];
   prod_type p2_ff [3];
   prod_type q2_ff [3];

   wide_type w3_in [3];
   rad_type  ss3_in;
   logic     v3_ff;
   cmd_type  cmd3_ff;
   word_type a3_ff [3];
   wide_type w3_ff [3];
   rad_type  ss3_ff;

   wide_type sh4 [3];
   sat_type  st4 [3];
   side_type side4_in;
   logic     v4_ff;
   side_type side4_ff;
   rad_type  rad4_ff;

   // stage 1: capture operands
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         cmd1_ff <= in_req.cmd;
         sc1_ff  <= word_type'(in_req.sc);
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= word_type'(in_req.a[i]);
            b1_ff[i] <= word_type'(in_req.b[i]);
         end
      end
   end

   // stage 2: operand select and products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mx[i] = a1_ff[i];
         my[i] = b1_ff[i];
         qx[i] = a1_ff[i];
         qy[i] = b1_ff[i];
      end
      unique case (cmd1_ff)
         CMD_CROSS: begin
            mx[0] = a1_ff[1]; my[0] = b1_ff[2]; qx[0] = a1_ff[2]; qy[0] = b1_ff[1];
            mx[1] = a1_ff[2]; my[1] = b1_ff[0]; qx[1] = a1_ff[0]; qy[1] = b1_ff[2];
            mx[2] = a1_ff[0]; my[2] = b1_ff[1]; qx[2] = a1_ff[1]; qy[2] = b1_ff[0];
         end
         CMD_MAG, CMD_NORM: begin
            for (int i = 0; i < 3; i++) my[i] = a1_ff[i];
         end
         CMD_SCALE: begin
            for (int i = 0; i < 3; i++) my[i] = sc1_ff;
         end
         default: ;
      endcase
      for (int i = 0; i < 3; i++) begin
         p2_in[i] = prod_type'(mx[i]) * prod_type'(my[i]);
         q2_in[i] = prod_type'(qx[i]) * prod_type'(qy[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         cmd2_ff <= cmd1_ff;
         for (int i = 0; i < 3; i++) begin
            a2_ff[i] <= a1_ff[i];
            b2_ff[i] <= b1_ff[i];
            p2_ff[i] <= p2_in[i];
            q2_ff[i] <= q2_in[i];
         end
      end
   end

   // stage 3: exact sums before truncation
   always_comb begin
      for (int i = 0; i < 3; i++) w3_in[i] = '0;
      ss3_in = rad_type'(p2_ff[0]) + rad_type'(p2_ff[1]) + rad_type'(p2_ff[2]);
      unique case (cmd2_ff)
         CMD_ADD: begin
            for (int i = 0; i < 3; i++) w3_in[i] = wide_type'(a2_ff[i]) + wide_type'(b2_ff[i]);
         end
         CMD_CROSS: begin
            for (int i = 0; i < 3; i++) w3_in[i] = wide_type'(p2_ff[i]) - wide_type'(q2_ff[i]);
         end
         CMD_DOT: begin
            w3_in[0] = wide_type'(p2_ff[0]) + wide_type'(p2_ff[1]) + wide_type'(p2_ff[2]);
         end
         CMD_SCALE: begin
            for (int i = 0; i < 3; i++) w3_in[i] = wide_type'(p2_ff[i]);
         end
         CMD_NEG: begin
            for (int i = 0; i < 3; i++) w3_in[i] = -wide_type'(a2_ff[i]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         cmd3_ff <= cmd2_ff;
         ss3_ff  <= ss3_in;
         for (int i = 0; i < 3; i++) begin
            a3_ff[i] <= a2_ff[i];
            w3_ff[i] <= w3_in[i];
         end
      end
   end

   // stage 4: floor shift, saturate, magnitudes for normalize
   always_comb begin
      side4_in     = '0;
      side4_in.cmd = cmd3_ff;
      for (int i = 0; i < 3; i++) begin
         sh4[i] = w3_ff[i];
         if (cmd3_ff == CMD_CROSS || cmd3_ff == CMD_DOT || cmd3_ff == CMD_SCALE) begin
            sh4[i] = w3_ff[i] >>> FRAC_BITS;
         end
         st4[i]           = sat_word(sh4[i]);
         side4_in.r[i]    = st4[i].val;
         side4_in.neg[i]  = a3_ff[i][IO_BITS-1];
         side4_in.mag[i]  = a3_ff[i][IO_BITS-1] ? mag_type'(-a3_ff[i]) : mag_type'(a3_ff[i]);
      end
      side4_in.ovf = st4[0].ovf | st4[1].ovf | st4[2].ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         side4_ff <= side4_in;
         rad4_ff  <= ss3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = side4_ff;
   assign out_rad   = rad4_ff;

endmodule

@@ rtl/v3a_sqrt.sv @@
// pipelined square root, one root bit per stage
`include "assert_macros.svh"

module v3a_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  v3a_pkg::side_type in_side,
   input  v3a_pkg::rad_type  in_rad,
   output logic              out_valid,
   output v3a_pkg::side_type out_side,
   output v3a_pkg::root_type out_root
);
   import v3a_pkg::*;

   logic     valid_ff [ROOT_BITS];
   side_type side_ff  [ROOT_BITS];
   rad_type  rad_ff   [ROOT_BITS];
   rem_type  rem_ff   [ROOT_BITS];
   root_type root_ff  [ROOT_BITS];
   rem_type  root_x2;

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      logic     v_prev;
      side_type side_prev;
      rad_type  rad_prev;
      rem_type  rem_prev;
      root_type root_prev;
      rem_type  rem_sh;
      rem_type  trial;
      rem_type  rem_in;
      root_type root_in;

      if (k == 0) begin : g_first
         always_comb begin
            v_prev    = in_valid;
            side_prev = in_side;
            rad_prev  = in_rad;
            rem_prev  = '0;
            root_prev = '0;
         end
      end else begin : g_next
         always_comb begin
            v_prev    = valid_ff[k-1];
            side_prev = side_ff[k-1];
            rad_prev  = rad_ff[k-1];
            rem_prev  = rem_ff[k-1];
            root_prev = root_ff[k-1];
         end
      end

      always_comb begin
         rem_sh = {rem_prev[REM_BITS-3:0], rad_prev[PROD_BITS-1 -: 2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[ROOT_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= v_prev;
         end
         if (adv) begin
            side_ff[k] <= side_prev;
            rad_ff[k]  <= {rad_prev[PROD_BITS-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign root_x2   = {1'b0, out_root, 1'b0};

   // floor root leaves a remainder of at most twice the root
   `V3A_ASSERT(a_sqrt_rem, out_valid |-> rem_ff[ROOT_BITS-1] <= root_x2)

endmodule

@@ rtl/v3a_div.sv @@
// pipelined restoring divide of each magnitude by the length
`include "assert_macros.svh"

module v3a_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  v3a_pkg::side_type     in_side,
   input  v3a_pkg::root_type     in_root,
   output logic                  out_valid,
   output v3a_pkg::side_type     out_side,
   output v3a_pkg::root_type     out_root,
   output v3a_pkg::quot_vec_type out_q
);
   import v3a_pkg::*;

   logic     valid_ff [QUOT_BITS];
   side_type side_ff  [QUOT_BITS];
   root_type m_ff     [QUOT_BITS];
   mag_type  rem_ff   [QUOT_BITS][3];
   quot_type nb_ff    [QUOT_BITS][3];
   quot_type q_ff     [QUOT_BITS][3];
   logic     norm_chk;
   logic     unit_ok;

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      logic               v_prev;
      side_type           side_prev;
      root_type           m_prev;
      mag_type            rem_prev [3];
      quot_type           nb_prev  [3];
      quot_type           q_prev   [3];
      logic [IO_BITS:0]   sh       [3];
      mag_type            rem_in   [3];
      quot_type           q_in     [3];

      if (k == 0) begin : g_first
         always_comb begin
            v_prev    = in_valid;
            side_prev = in_side;
            m_prev    = in_root;
            for (int c = 0; c < 3; c++) begin
               rem_prev[c] = in_side.mag[c] >> 1;
               nb_prev[c]  = {in_side.mag[c][0], {FRAC_BITS{1'b0}}};
               q_prev[c]   = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            v_prev    = valid_ff[k-1];
            side_prev = side_ff[k-1];
            m_prev    = m_ff[k-1];
            for (int c = 0; c < 3; c++) begin
               rem_prev[c] = rem_ff[k-1][c];
               nb_prev[c]  = nb_ff[k-1][c];
               q_prev[c]   = q_ff[k-1][c];
            end
         end
      end

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            sh[c] = {rem_prev[c], nb_prev[c][QUOT_BITS-1]};
            if (sh[c] >= {1'b0, m_prev}) begin
               rem_in[c] = mag_type'(sh[c] - {1'b0, m_prev});
               q_in[c]   = {q_prev[c][QUOT_BITS-2:0], 1'b1};
            end else begin
               rem_in[c] = mag_type'(sh[c]);
               q_in[c]   = {q_prev[c][QUOT_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= v_prev;
         end
         if (adv) begin
            side_ff[k] <= side_prev;
            m_ff[k]    <= m_prev;
            for (int c = 0; c < 3; c++) begin
               rem_ff[k][c] <= rem_in[c];
               nb_ff[k][c]  <= {nb_prev[c][QUOT_BITS-2:0], 1'b0};
               q_ff[k][c]   <= q_in[c];
            end
         end
      end
   end

   assign out_valid = valid_ff[QUOT_BITS-1];
   assign out_side  = side_ff[QUOT_BITS-1];
   assign out_root  = m_ff[QUOT_BITS-1];
   assign out_q     = {q_ff[QUOT_BITS-1][2], q_ff[QUOT_BITS-1][1], q_ff[QUOT_BITS-1][0]};

   assign norm_chk = out_valid && out_side.cmd == CMD_NORM && out_root != '0;
   assign unit_ok  = out_q[0] <= ONE_Q && out_q[1] <= ONE_Q && out_q[2] <= ONE_Q;

   // a unit vector component never exceeds one
   `V3A_ASSERT(a_div_unit, norm_chk |-> unit_ok)

endmodule

@@ rtl/vector3_alu.sv @@
// top level of the three-component fixed point vector unit
//
// Takes one beat per clock while the response side keeps up and returns one
// result beat per request, in order: four stages of operand capture,
// 32x32 multipliers, exact sums and saturation, then a 32-stage square
// root (one root bit per stage) and a 17-stage divide (one quotient bit
// per stage) that every beat passes through, then the output register.
// All operations pass through the root and divide pipelines alike. A
// stall on the response side freezes the whole pipeline, and a waiting
// result does not stop a new request from entering while the response
// register is being emptied in the same cycle.
`include "assert_macros.svh"

module vector3_alu (
   input logic        clock,
   input logic        reset,
   v3a_req_if.sink    req_bus,
   v3a_rsp_if.source  rsp_bus
);
   import v3a_pkg::*;

   logic         adv;
   req_type      req_in;
   logic         front_valid;
   side_type     front_side;
   rad_type      front_rad;
   logic         sqrt_valid;
   side_type     sqrt_side;
   root_type     sqrt_root;
   logic         div_valid;
   side_type     div_side;
   root_type     div_root;
   quot_vec_type div_q;

   logic [IO_BITS-1:0]      nq [3];
   logic [2:0][IO_BITS-1:0] rsp_r_in;
   logic                    rsp_ovf_in;
   logic                    rsp_dbz_in;
   logic                    rsp_valid_ff;
   logic [2:0][IO_BITS-1:0] rsp_r_ff;
   logic                    rsp_ovf_ff;
   logic                    rsp_dbz_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_comb begin
      req_in.cmd  = req_bus.cmd;
      req_in.a[0] = req_bus.ax[IO_BITS-1:0];
      req_in.a[1] = req_bus.ay[IO_BITS-1:0];
      req_in.a[2] = req_bus.az[IO_BITS-1:0];
      req_in.b[0] = req_bus.bx[IO_BITS-1:0];
      req_in.b[1] = req_bus.by[IO_BITS-1:0];
      req_in.b[2] = req_bus.bz[IO_BITS-1:0];
      req_in.sc   = req_bus.scale[IO_BITS-1:0];
   end

   v3a_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_bus.valid),
      .in_req    (req_in),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_rad   (front_rad)
   );

   v3a_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_rad    (front_rad),
      .out_valid (sqrt_valid),
      .out_side  (sqrt_side),
      .out_root  (sqrt_root)
   );

   v3a_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sqrt_valid),
      .in_side   (sqrt_side),
      .in_root   (sqrt_root),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_root  (div_root),
      .out_q     (div_q)
   );

   // final result select
   always_comb begin
      rsp_r_in   = div_side.r;
      rsp_ovf_in = div_side.ovf;
      rsp_dbz_in = 1'b0;
      for (int c = 0; c < 3; c++) nq[c] = IO_BITS'(div_q[c]);
      unique case (div_side.cmd)
         CMD_MAG: begin
            rsp_r_in = '0;
            if (div_root[IO_BITS-1]) begin
               rsp_r_in[0] = WORD_MAX;
               rsp_ovf_in  = 1'b1;
            end else begin
               rsp_r_in[0] = div_root;
            end
         end
         CMD_NORM: begin
            rsp_r_in = '0;
            if (div_root == '0) begin
               rsp_dbz_in = 1'b1;
            end else begin
               for (int c = 0; c < 3; c++) begin
                  rsp_r_in[c] = div_side.neg[c] ? (-nq[c]) : nq[c];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
      if (adv) begin
         rsp_r_ff   <= rsp_r_in;
         rsp_ovf_ff <= rsp_ovf_in;
         rsp_dbz_ff <= rsp_dbz_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.res_x          = FIELD_BITS'(signed'(rsp_r_ff[0]));
   assign rsp_bus.res_y          = FIELD_BITS'(signed'(rsp_r_ff[1]));
   assign rsp_bus.res_z          = FIELD_BITS'(signed'(rsp_r_ff[2]));
   assign rsp_bus.overflow       = rsp_ovf_ff;
   assign rsp_bus.divide_by_zero = rsp_dbz_ff;

   `V3A_ASSERT(a_dbz_zero, rsp_valid_ff && rsp_dbz_ff |-> rsp_r_ff == '0 && !rsp_ovf_ff)
   `V3A_ASSERT(a_flags_apart, rsp_valid_ff && rsp_ovf_ff |-> !rsp_dbz_ff)
   `V3A_ASSERT_NEXT(a_out_load, adv && div_valid, rsp_valid_ff)

endmodule
